### rtl/core/ipf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_pkg
// shared types and constants of the exact-match address filter
// ----------------------------------------------------------------------------
package ipf_pkg;

    localparam int SET_CAPACITY_DEF  = 1024;
    localparam int BLACKLIST_CAP_DEF = 1024;

    // prefix map: 65536 flags of the top 16 address bits, kept as 32-bit rows
    localparam int PREFIX_BITS  = 16;
    localparam int PREFIX_ROW_W = 32;
    localparam int PREFIX_ROWS  = (1 << PREFIX_BITS) / PREFIX_ROW_W;
    localparam int ROW_AW       = $clog2(PREFIX_ROWS);
    localparam int SEL_W        = $clog2(PREFIX_ROW_W);

    localparam int COUNT_OUT_W  = 11;

    typedef enum logic [1:0] {
        OP_CHECK     = 2'd0,
        OP_BLACK_ADD = 2'd1,
        OP_WATCH_ADD = 2'd2,
        OP_REMOVE    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_CAP  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_CMP,
        S_EXEC,
        S_MOVE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic start;
        logic scan_rd;
        logic scan_next;
        logic mark_found;
        logic exec;
        logic move_wr;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic scan_end;
        logic hit;
        logic need_move;
        logic out_free;
    } t_sts;

endpackage

### rtl/core/ipf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module ipf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/ipf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_ctrl
// sequencer: prefix clear, store scan, execute, compaction move, result
// ----------------------------------------------------------------------------
module ipf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ipf_pkg::t_sts i_sts,
    output ipf_pkg::t_cmd o_cmd
);
    import ipf_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_end) begin
                    n_state = S_EXEC;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                    n_state       = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.hit) begin
                    o_cmd.mark_found = 1'b1;
                    n_state          = S_EXEC;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.need_move ? S_MOVE : S_DONE;
            end
            S_MOVE: begin
                o_cmd.move_wr = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule

### rtl/core/ipf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipf_datapath
// address store, prefix map, counters and result register
// ----------------------------------------------------------------------------
module ipf_datapath #(
    parameter int SET_CAPACITY  = ipf_pkg::SET_CAPACITY_DEF,
    parameter int BLACKLIST_CAP = ipf_pkg::BLACKLIST_CAP_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ipf_pkg::t_cmd i_cmd,
    output ipf_pkg::t_sts o_sts,
    input  logic [1:0]    i_opcode,
    input  logic [31:0]   i_ip_address,
    input  logic          i_ready,
    output logic          o_valid,
    output logic          o_drop,
    output logic          o_prefix_hit,
    output logic [1:0]    o_status,
    output logic [10:0]   o_entry_count,
    output logic [10:0]   o_blacklist_total,
    output logic [31:0]   o_dropped_total,
    output logic [31:0]   o_passed_total
);
    import ipf_pkg::*;

    localparam int IDX_W = $clog2(SET_CAPACITY);
    localparam int CNT_W = $clog2(SET_CAPACITY + 1);
    localparam int BL_W  = $clog2(BLACKLIST_CAP + 1);

    t_opcode           r_op;
    logic [31:0]       r_ip;
    logic [CNT_W-1:0]  r_idx;
    logic              r_found;
    logic [CNT_W-1:0]  r_count;
    logic [BL_W-1:0]   r_bl;
    logic [31:0]       r_drop_t;
    logic [31:0]       r_pass_t;
    logic [ROW_AW-1:0] r_clr;
    logic              r_drop;
    logic              r_hit;
    t_status           r_status;
    logic              r_out_valid;
    logic              r_o_drop;
    logic              r_o_hit;
    t_status           r_o_status;
    logic [COUNT_OUT_W-1:0] r_o_count;
    logic [COUNT_OUT_W-1:0] r_o_bl;
    logic [31:0]       r_o_drop_t;
    logic [31:0]       r_o_pass_t;

    logic [31:0]             store_rdata;
    logic                    store_we;
    logic [IDX_W-1:0]        store_waddr;
    logic                    store_re;
    logic [IDX_W-1:0]        store_raddr;
    logic [PREFIX_ROW_W-1:0] pfx_rdata;
    logic                    pfx_we;
    logic [ROW_AW-1:0]       pfx_waddr;
    logic [PREFIX_ROW_W-1:0] pfx_wdata;
    logic [SEL_W-1:0]        sel;
    logic [PREFIX_ROW_W-1:0] sel_mask;
    logic                    bl_ok;
    logic                    do_insert;
    logic                    ins_new;
    logic                    ins_full;
    logic [CNT_W-1:0]        last_idx;

    assign sel      = r_ip[31-ROW_AW -: SEL_W];
    assign sel_mask = PREFIX_ROW_W'(1) << sel;
    assign last_idx = r_count - CNT_W'(1);

    // operation decode
    assign bl_ok     = (r_op == OP_BLACK_ADD) && (r_bl < BL_W'(BLACKLIST_CAP));
    assign do_insert = bl_ok || (r_op == OP_WATCH_ADD);
    assign ins_new   = do_insert && !r_found && (r_count < CNT_W'(SET_CAPACITY));
    assign ins_full  = do_insert && !r_found && !(r_count < CNT_W'(SET_CAPACITY));

    always_comb begin
        store_we    = 1'b0;
        store_waddr = r_count[IDX_W-1:0];
        store_re    = 1'b0;
        store_raddr = r_idx[IDX_W-1:0];
        if (i_cmd.exec && ins_new) begin
            store_we = 1'b1;
        end
        if (i_cmd.move_wr) begin
            store_we    = 1'b1;
            store_waddr = r_idx[IDX_W-1:0];
        end
        if (i_cmd.scan_rd) begin
            store_re = 1'b1;
        end
        // fetch last entry to fill the hole left by a remove
        if (i_cmd.exec && r_op == OP_REMOVE && r_found) begin
            store_re    = 1'b1;
            store_raddr = last_idx[IDX_W-1:0];
        end
    end

    always_comb begin
        pfx_we    = 1'b0;
        pfx_waddr = r_clr;
        pfx_wdata = '0;
        if (i_cmd.clr_step) begin
            pfx_we = 1'b1;
        end else if (i_cmd.exec && bl_ok) begin
            pfx_we    = 1'b1;
            pfx_waddr = r_ip[31 -: ROW_AW];
            pfx_wdata = pfx_rdata | sel_mask;
        end
    end

    ipf_ram #(.WIDTH(32), .DEPTH(SET_CAPACITY)) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (i_cmd.move_wr ? store_rdata : r_ip),
        .i_re    (store_re),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    ipf_ram #(.WIDTH(PREFIX_ROW_W), .DEPTH(PREFIX_ROWS)) u_prefix (
        .i_clk   (i_clk),
        .i_we    (pfx_we),
        .i_waddr (pfx_waddr),
        .i_wdata (pfx_wdata),
        .i_re    (i_cmd.start),
        .i_raddr (i_ip_address[31 -: ROW_AW]),
        .o_rdata (pfx_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_bl        <= '0;
            r_drop_t    <= '0;
            r_pass_t    <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (i_cmd.clr_step) r_clr <= r_clr + ROW_AW'(1);
            if (i_cmd.start) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.scan_next)  r_idx   <= r_idx + CNT_W'(1);
            if (i_cmd.mark_found) r_found <= 1'b1;
            if (i_cmd.exec) begin
                if (r_op == OP_CHECK) begin
                    if (r_found) r_drop_t <= r_drop_t + 32'd1;
                    else         r_pass_t <= r_pass_t + 32'd1;
                end
                if (bl_ok)   r_bl    <= r_bl + BL_W'(1);
                if (ins_new) r_count <= r_count + CNT_W'(1);
                if (r_op == OP_REMOVE && r_found) r_count <= last_idx;
            end
            if (i_cmd.load_out)     r_out_valid <= 1'b1;
            else if (i_ready)       r_out_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op <= t_opcode'(i_opcode);
            r_ip <= i_ip_address;
        end
        if (i_cmd.exec) begin
            r_drop   <= (r_op == OP_CHECK) && r_found;
            r_hit    <= pfx_rdata[sel] | bl_ok;
            r_status <= ((r_op == OP_BLACK_ADD) && !bl_ok) ? ST_CAP :
                        (ins_full ? ST_FULL : ST_OK);
        end
        if (i_cmd.load_out) begin
            r_o_drop   <= r_drop;
            r_o_hit    <= r_hit;
            r_o_status <= r_status;
            r_o_count  <= COUNT_OUT_W'(r_count);
            r_o_bl     <= COUNT_OUT_W'(r_bl);
            r_o_drop_t <= r_drop_t;
            r_o_pass_t <= r_pass_t;
        end
    end

    assign o_sts.clr_last  = (r_clr == ROW_AW'(PREFIX_ROWS - 1));
    assign o_sts.scan_end  = (r_idx == r_count);
    assign o_sts.hit       = (store_rdata == r_ip);
    assign o_sts.need_move = (r_op == OP_REMOVE) && r_found;
    assign o_sts.out_free  = !r_out_valid || i_ready;

    // counters are captured with the result, so a following request cannot disturb them
    assign o_valid           = r_out_valid;
    assign o_drop            = r_o_drop;
    assign o_prefix_hit      = r_o_hit;
    assign o_status          = r_o_status;
    assign o_entry_count     = r_o_count;
    assign o_blacklist_total = r_o_bl;
    assign o_dropped_total   = r_o_drop_t;
    assign o_passed_total    = r_o_pass_t;

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(SET_CAPACITY))
        else $error("entry count above capacity");
    a_bl_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bl <= BL_W'(BLACKLIST_CAP))
        else $error("blacklist tally above cap");
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |=> r_out_valid)
        else $error("result not presented after load");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_rd |-> r_idx < r_count)
        else $error("scan read beyond held entries");

endmodule

### rtl/core/ip_address_exact_match_filter_top.sv
`timescale 1ns / 1ps
// scan: from request accept to result valid, the stored addresses are read one per SCAN/CMP pair
//   through the store's single read port; a hit ends the scan early
// requests: one at a time, with no new accept until the result of the last one is loaded;
//   a new request is taken while a result still waits
// reset: synchronous active low; afterwards a pass clears all 2048 rows of the prefix map,
//   one 32-bit row per cycle, with ready low
// ----------------------------------------------------------------------------
// ip_address_exact_match_filter_top
// exact-match ipv4 set with a 16-bit prefix flag map
// ----------------------------------------------------------------------------
module ip_address_exact_match_filter_top #(
    parameter int SET_CAPACITY  = ipf_pkg::SET_CAPACITY_DEF,
    parameter int BLACKLIST_CAP = ipf_pkg::BLACKLIST_CAP_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [31:0] i_ip_address,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_drop,
    output logic        o_prefix_hit,
    output logic [1:0]  o_status,
    output logic [10:0] o_entry_count,
    output logic [10:0] o_blacklist_total,
    output logic [31:0] o_dropped_total,
    output logic [31:0] o_passed_total
);
    import ipf_pkg::*;

    // commands from the sequencer, status back from the datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: clear pass, then per request scan / execute / optional move / result
    ipf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // datapath: set kept packed in slots 0..count-1, remove moves the last entry
    // into the freed slot so scans never see holes
    ipf_datapath #(
        .SET_CAPACITY  (SET_CAPACITY),
        .BLACKLIST_CAP (BLACKLIST_CAP)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_opcode          (i_opcode),
        .i_ip_address      (i_ip_address),
        .i_ready           (i_ready),
        .o_valid           (o_valid),
        .o_drop            (o_drop),
        .o_prefix_hit      (o_prefix_hit),
        .o_status          (o_status),
        .o_entry_count     (o_entry_count),
        .o_blacklist_total (o_blacklist_total),
        .o_dropped_total   (o_dropped_total),
        .o_passed_total    (o_passed_total)
    );

endmodule
